// File: src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside of reset.
`define PNH_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error(msg);

// Condition that must hold at every clock edge outside of reset.
`define PNH_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

// File: src/pnh_pkg.sv
// ----------------------------------------------------------------------------
// Perlin noise height package
// Hash constants, fixed-point constants and the gradient table generator.
// ----------------------------------------------------------------------------
package pnh_pkg;

  localparam logic [31:0] HASH_MUL_A = 32'd3284157443;
  localparam logic [31:0] HASH_MUL_B = 32'd1911520717;
  localparam logic [31:0] HASH_MUL_C = 32'd2048419325;

  localparam longint PI_Q30  = 64'sd3373259426;
  localparam longint ONE_Q30 = 64'sd1073741824;

  localparam int HEIGHT_SCALE = 24;
  localparam int HEIGHT_MAX   = 48;

  function automatic logic [31:0] rot16(input logic [31:0] v);
    return {v[15:0], v[31:16]};
  endfunction

  // Quotient rounded toward zero, found by shift and subtract. It only
  // feeds the gradient table values computed at elaboration.
  function automatic longint div_trunc(input longint num, input longint den);
    longint mag;
    longint dmag;
    longint rem;
    longint quo;
    mag  = (num < 0) ? -num : num;
    dmag = (den < 0) ? -den : den;
    rem  = 0;
    quo  = 0;
    for (int i = 62; i >= 0; i--) begin
      rem = (rem <<< 1) | ((mag >>> i) & 64'sd1);
      if (rem >= dmag) begin
        rem = rem - dmag;
        quo = quo | (64'sd1 <<< i);
      end
    end
    return ((num < 0) != (den < 0)) ? -quo : quo;
  endfunction

  // Cosine or sine of angle j*pi/2^(atb-1) in Q15, evaluated at elaboration
  // with truncated Q30 Taylor terms.
  function automatic logic [15:0] trig_q15(input int j, input int atb,
                                           input logic want_cos);
    longint t;
    longint ts;
    longint tc;
    longint ss;
    longint sc;
    longint v;
    longint r;
    t  = (longint'(j) * PI_Q30) >>> (atb - 1);
    ts = t;
    tc = ONE_Q30;
    ss = t;
    sc = ONE_Q30;
    for (int n = 1; n <= 7; n++) begin
      ts = div_trunc(ts * t, ONE_Q30);
      ts = div_trunc(ts * t, ONE_Q30);
      ts = div_trunc(-ts, longint'((2 * n) * (2 * n + 1)));
      ss = ss + ts;
      tc = div_trunc(tc * t, ONE_Q30);
      tc = div_trunc(tc * t, ONE_Q30);
      tc = div_trunc(-tc, longint'((2 * n - 1) * (2 * n)));
      sc = sc + tc;
    end
    v = want_cos ? sc : ss;
    if (v < 0) begin
      v = 0;
    end
    r = (v + 64'sd16384) >>> 15;
    if (r > 64'sd32767) begin
      r = 64'sd32767;
    end
    return r[15:0];
  endfunction

endpackage

// File: src/pnh_hash.sv
// ----------------------------------------------------------------------------
// Corner hash
// Three-stage multiply, xor and rotate hash of one lattice corner.
// ----------------------------------------------------------------------------
module pnh_hash (
  input  logic        clk,
  input  logic [31:0] cx,
  input  logic [31:0] cz,
  output logic [31:0] hash
);
  import pnh_pkg::*;

  logic [31:0] a1_r;
  logic [31:0] cz1_r;
  logic [31:0] a2_r;
  logic [31:0] b2_r;
  logic [31:0] h3_r;

  always_ff @(posedge clk) begin
    a1_r  <= cx * HASH_MUL_A;
    cz1_r <= cz;
    a2_r  <= a1_r;
    b2_r  <= (cz1_r ^ rot16(a1_r)) * HASH_MUL_B;
    h3_r  <= (a2_r ^ rot16(b2_r)) * HASH_MUL_C;
  end

  assign hash = h3_r;

endmodule

// File: src/perlin_noise_height_unit.sv
// ----------------------------------------------------------------------------
// Perlin noise height unit
// Terrain height from 2D gradient noise over a signed column coordinate.
// ----------------------------------------------------------------------------
//
//  Channel  | Ports                                 | Handshake
//  ---------+---------------------------------------+-----------------------
//  input    | start, busy, in_column_x, in_column_z | start high, busy low
//  result   | out_valid, out_height                 | one-cycle strobe
//
// The unit is a fully pipelined datapath: it accepts one request in every
// clock cycle and returns one result per request, in request order, after
// the input register, three hash stages, the gradient lookup, the dot
// products, two multiply-then-add blend steps and the height register.
// busy is always low because nothing in the pipeline ever waits. Reset
// (synchronous, active low) clears only the valid bits that travel with
// each request; the data registers hold whatever they held. The receiver
// cannot stall the unit, so each result is shown for exactly one cycle.
//
module perlin_noise_height_unit #(
  parameter int ANGLE_TABLE_BITS = 10,
  parameter int SCALE_SHIFT      = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_column_x,
  input  logic signed [31:0] in_column_z,
  output logic               out_valid,
  output logic [5:0]         out_height
);
  import pnh_pkg::*;

  // Fraction width, weight width, dot product width and so on.
  localparam int S       = SCALE_SHIFT;
  localparam int FW      = S + 1;             // fraction, unsigned
  localparam int OW      = S + 2;             // corner offset, signed
  localparam int WW      = 3 * S + 3;         // smoothstep weight, unsigned
  localparam int DW      = S + 19;            // dot products and blends
  localparam int PW      = DW + 1 + WW + 1;   // blend product
  localparam int HW      = DW + 8;            // height scaling
  localparam int QUARTER = 1 << (ANGLE_TABLE_BITS - 2);
  localparam int HALF    = QUARTER / 2;
  localparam int JW      = ANGLE_TABLE_BITS - 2;
  localparam int NSTAGE  = 11;

  localparam logic [31:0]          FRAC_MASK = (32'd1 << S) - 32'd1;
  localparam logic signed [OW-1:0] ONE_OFS   = OW'(1) << S;
  localparam logic [WW-1:0]        THREE_ONE = WW'(3) << S;
  localparam logic signed [HW-1:0] BIAS      = HW'(1) << (15 + S);
  localparam logic signed [HW-1:0] H_SCALE   = HW'(HEIGHT_SCALE);
  localparam logic signed [HW-1:0] H_MAX     = HW'(HEIGHT_MAX);

  // Gradient table for one octant: cosine and sine of angles 0 to pi/4.
  logic [15:0] cos_tab [HALF+1];
  logic [15:0] sin_tab [HALF+1];

  for (genvar g = 0; g <= HALF; g++) begin : g_tab
    localparam logic [15:0] COS_V = trig_q15(g, ANGLE_TABLE_BITS, 1'b1);
    localparam logic [15:0] SIN_V = trig_q15(g, ANGLE_TABLE_BITS, 1'b0);
    assign cos_tab[g] = COS_V;
    assign sin_tab[g] = SIN_V;
  end

  // Valid bits, one per pipeline register stage.
  logic [NSTAGE:1] v_r;
  logic [NSTAGE:1] v_nxt;

  always_comb begin
    v_nxt = {v_r[NSTAGE-1:1], start};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // Stage 1: input register.
  logic signed [31:0] x_r;
  logic signed [31:0] z_r;

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= in_column_x;
      z_r <= in_column_z;
    end
  end

  // Lattice cells; the arithmetic shift rounds toward minus infinity and the
  // upper corner wraps modulo 2^32.
  logic [31:0] cx0;
  logic [31:0] cz0;
  logic [31:0] cx1;
  logic [31:0] cz1;
  logic [31:0] hash [4];

  assign cx0 = 32'(x_r >>> S);
  assign cz0 = 32'(z_r >>> S);
  assign cx1 = cx0 + 32'd1;
  assign cz1 = cz0 + 32'd1;

  // Stages 2 to 4: corner hashes.
  pnh_hash u_hash0 (.clk(clk), .cx(cx0), .cz(cz0), .hash(hash[0]));
  pnh_hash u_hash1 (.clk(clk), .cx(cx1), .cz(cz0), .hash(hash[1]));
  pnh_hash u_hash2 (.clk(clk), .cx(cx0), .cz(cz1), .hash(hash[2]));
  pnh_hash u_hash3 (.clk(clk), .cx(cx1), .cz(cz1), .hash(hash[3]));

  // Fractions and smoothstep weights run alongside the hash.
  logic [FW-1:0] fx2_r, fz2_r, fx3_r, fz3_r, fx4_r, fz4_r, fx5_r, fz5_r;
  logic [WW-1:0] wax3_r, waz3_r, wx4_r, wz4_r, wx5_r, wz5_r;
  logic [WW-1:0] wx6_r, wz6_r, wz7_r, wz8_r;

  always_ff @(posedge clk) begin
    fx2_r  <= FW'(32'(x_r) & FRAC_MASK);
    fz2_r  <= FW'(32'(z_r) & FRAC_MASK);
    fx3_r  <= fx2_r;
    fz3_r  <= fz2_r;
    wax3_r <= (THREE_ONE - (WW'(fx2_r) << 1)) * WW'(fx2_r);
    waz3_r <= (THREE_ONE - (WW'(fz2_r) << 1)) * WW'(fz2_r);
    fx4_r  <= fx3_r;
    fz4_r  <= fz3_r;
    wx4_r  <= wax3_r * WW'(fx3_r);
    wz4_r  <= waz3_r * WW'(fz3_r);
    fx5_r  <= fx4_r;
    fz5_r  <= fz4_r;
    wx5_r  <= wx4_r;
    wz5_r  <= wz4_r;
    wx6_r  <= wx5_r;
    wz6_r  <= wz5_r;
    wz7_r  <= wz6_r;
    wz8_r  <= wz7_r;
  end

  // Stage 5: gradient lookup. The top hash bits give a quadrant and an
  // offset inside it; offsets past the octant mirror with cosine and sine
  // swapped.
  logic signed [15:0] gx_nxt [4];
  logic signed [15:0] gy_nxt [4];
  logic signed [15:0] gx5_r  [4];
  logic signed [15:0] gy5_r  [4];

  always_comb begin
    logic [ANGLE_TABLE_BITS-1:0] idx;
    logic [1:0]                  quad;
    logic [JW-1:0]               m;
    logic                        flip;
    logic [JW-1:0]               j;
    logic signed [15:0]          c;
    logic signed [15:0]          s;
    for (int k = 0; k < 4; k++) begin
      idx  = hash[k][31 -: ANGLE_TABLE_BITS];
      quad = idx[ANGLE_TABLE_BITS-1 -: 2];
      m    = idx[JW-1:0];
      flip = (32'(m) > 32'(HALF));
      j    = flip ? JW'(32'(QUARTER) - 32'(m)) : m;
      if (flip) begin
        c = $signed(sin_tab[j]);
        s = $signed(cos_tab[j]);
      end else begin
        c = $signed(cos_tab[j]);
        s = $signed(sin_tab[j]);
      end
      unique case (quad)
        2'd0: begin gx_nxt[k] = c;  gy_nxt[k] = s;  end
        2'd1: begin gx_nxt[k] = -s; gy_nxt[k] = c;  end
        2'd2: begin gx_nxt[k] = -c; gy_nxt[k] = -s; end
        default: begin gx_nxt[k] = s; gy_nxt[k] = -c; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      gx5_r[k] <= gx_nxt[k];
      gy5_r[k] <= gy_nxt[k];
    end
  end

  // Stage 6: dot products of each gradient with the offset from its corner.
  logic signed [OW-1:0] dx0, dz0, dx1, dz1;
  logic signed [DW-1:0] dot_nxt [4];
  logic signed [DW-1:0] dot6_r  [4];

  assign dx0 = $signed({1'b0, fx5_r});
  assign dz0 = $signed({1'b0, fz5_r});
  assign dx1 = dx0 - ONE_OFS;
  assign dz1 = dz0 - ONE_OFS;

  always_comb begin
    dot_nxt[0] = DW'(gx5_r[0]) * DW'(dx0) + DW'(gy5_r[0]) * DW'(dz0);
    dot_nxt[1] = DW'(gx5_r[1]) * DW'(dx1) + DW'(gy5_r[1]) * DW'(dz0);
    dot_nxt[2] = DW'(gx5_r[2]) * DW'(dx0) + DW'(gy5_r[2]) * DW'(dz1);
    dot_nxt[3] = DW'(gx5_r[3]) * DW'(dx1) + DW'(gy5_r[3]) * DW'(dz1);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      dot6_r[k] <= dot_nxt[k];
    end
  end

  // Stages 7 and 8: blend along x, multiply first, then shift and add.
  logic signed [PW-1:0] wxs;
  logic signed [PW-1:0] px7_r [2];
  logic signed [DW-1:0] a7_r  [2];
  logic signed [DW-1:0] row8_r [2];

  assign wxs = PW'($signed({1'b0, wx6_r}));

  always_ff @(posedge clk) begin
    px7_r[0]  <= PW'(dot6_r[1] - dot6_r[0]) * wxs;
    px7_r[1]  <= PW'(dot6_r[3] - dot6_r[2]) * wxs;
    a7_r[0]   <= dot6_r[0];
    a7_r[1]   <= dot6_r[2];
    row8_r[0] <= a7_r[0] + DW'(px7_r[0] >>> (3 * S));
    row8_r[1] <= a7_r[1] + DW'(px7_r[1] >>> (3 * S));
  end

  // Stages 9 and 10: blend the two rows along z.
  logic signed [PW-1:0] pz9_r;
  logic signed [DW-1:0] a9_r;
  logic signed [DW-1:0] noise10_r;

  always_ff @(posedge clk) begin
    pz9_r     <= PW'(row8_r[1] - row8_r[0]) * PW'($signed({1'b0, wz8_r}));
    a9_r      <= row8_r[0];
    noise10_r <= a9_r + DW'(pz9_r >>> (3 * S));
  end

  // Stage 11: scale to a height, floor and clamp.
  logic signed [HW-1:0] hs;
  logic [5:0]           height_nxt;
  logic [5:0]           height_r;

  always_comb begin
    hs = ((HW'(noise10_r) + BIAS) * H_SCALE) >>> (15 + S);
    priority if (hs < 0) begin
      height_nxt = 6'd0;
    end else if (hs > H_MAX) begin
      height_nxt = 6'(HEIGHT_MAX);
    end else begin
      height_nxt = hs[5:0];
    end
  end

  always_ff @(posedge clk) begin
    height_r <= height_nxt;
  end

  assign busy       = 1'b0;
  assign out_valid  = v_r[NSTAGE];
  assign out_height = height_r;

endmodule

// File: src/pnh_checker.sv
// ----------------------------------------------------------------------------
// Perlin noise height checker
// Port-level checks of latency, range and the idle busy line.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pnh_port_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [5:0]  out_valid_h,
  input logic        out_valid
);

  `PNH_ASSERT_ALWAYS(a_never_busy, !busy, "busy raised")
  `PNH_ASSERT_IMPL(a_range, out_valid, (out_valid_h <= 6'd48), "height out of range")
  `PNH_ASSERT_IMPL(a_latency, start && !busy, ##11 out_valid, "result missing")
  `PNH_ASSERT_IMPL(a_no_extra, out_valid, $past(start, 11), "result without request")

endmodule

bind perlin_noise_height_unit pnh_port_checker u_pnh_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid_h(out_height),
  .out_valid  (out_valid)
);
